FILE: sv/ptk_pkg.sv
package ptk_pkg;

  localparam int SCORE_W    = 32;
  localparam int POS_W      = 16;
  localparam int RANK_POS_W = 17;
  localparam int RANK_W     = 3;
  localparam int BEAM_W     = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [RANK_POS_W-1:0] NO_POSITION = '1;

  typedef struct packed {
    logic              load;
    logic [BEAM_W-1:0] count;
    logic [BEAM_W-1:0] used;
  } emit_req_t;

endpackage

FILE: sv/ptk_slots.sv
module ptk_slots #(
  parameter int MAX_BEAM    = 8,
  parameter int MAX_SEQ_LEN = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 beat,
  input  logic signed [ptk_pkg::SCORE_W-1:0]   score,
  input  logic                                 last,
  input  logic [ptk_pkg::BEAM_W-1:0]           beam,
  output ptk_pkg::emit_req_t                   req,
  output logic [ptk_pkg::POS_W-1:0]            ranked_pos [MAX_BEAM]
);
  import ptk_pkg::*;

  localparam int FW      = $clog2(MAX_BEAM + 1);
  localparam int CW      = (FW > BEAM_W) ? FW : BEAM_W;
  localparam int IW      = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
  localparam int MAXK    = (MAX_BEAM > 15) ? 15 : MAX_BEAM;
  localparam int POS_LIM = (MAX_SEQ_LEN - 1 > 65535) ? 65535 : MAX_SEQ_LEN - 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_LIM[POS_W-1:0];

  logic signed [SCORE_W-1:0] slot_score_r   [MAX_BEAM];
  logic signed [SCORE_W-1:0] slot_score_nxt [MAX_BEAM];
  logic [POS_W-1:0]          slot_pos_r     [MAX_BEAM];
  logic [POS_W-1:0]          slot_pos_nxt   [MAX_BEAM];
  logic [FW-1:0]             filled_r, filled_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;

  logic [BEAM_W-1:0] k;
  logic [CW-1:0]     k_ext, filled_ext, used, used_after;
  logic [MAX_BEAM-1:0] ge;
  logic              ins;

  always_comb begin
    if (beam == '0) begin
      k = BEAM_W'(1);
    end else if (beam > BEAM_W'(MAXK)) begin
      k = BEAM_W'(MAXK);
    end else begin
      k = beam;
    end
    k_ext      = CW'(k);
    filled_ext = CW'(filled_r);
    used       = (filled_ext < k_ext) ? filled_ext : k_ext;
  end

  always_comb begin
    for (int i = 0; i < MAX_BEAM; i++) begin
      ge[i] = (CW'(i) < used) && (slot_score_r[i] >= score);
    end
  end

  assign ins        = !ge[IW'(k - BEAM_W'(1))];
  assign used_after = ins ? ((used == k_ext) ? k_ext : used + CW'(1)) : used;

  always_comb begin
    for (int i = 0; i < MAX_BEAM; i++) begin
      slot_score_nxt[i] = slot_score_r[i];
      slot_pos_nxt[i]   = slot_pos_r[i];
      if (CW'(i) < k_ext && !ge[i]) begin
        if (i == 0) begin
          slot_score_nxt[i] = score;
          slot_pos_nxt[i]   = pos_r;
        end else if (ge[(i > 0) ? i - 1 : 0]) begin
          slot_score_nxt[i] = score;
          slot_pos_nxt[i]   = pos_r;
        end else begin
          slot_score_nxt[i] = slot_score_r[(i > 0) ? i - 1 : 0];
          slot_pos_nxt[i]   = slot_pos_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    filled_nxt = filled_r;
    pos_nxt    = pos_r;
    if (beat) begin
      if (last) begin
        filled_nxt = '0;
        pos_nxt    = '0;
      end else begin
        filled_nxt = ins ? FW'(used_after) : filled_r;
        pos_nxt    = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      pos_r    <= '0;
    end else begin
      filled_r <= filled_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      slot_score_r <= slot_score_nxt;
      slot_pos_r   <= slot_pos_nxt;
    end
  end

  assign ranked_pos = slot_pos_nxt;
  assign req.load   = beat && last;
  assign req.count  = k;
  assign req.used   = BEAM_W'(used_after);

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && last) |=> (filled_r == '0 && pos_r == '0))
    else $error("slots not cleared after end of sequence");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("position counter beyond limit");

endmodule

FILE: sv/ptk_emit.sv
module ptk_emit #(
  parameter int MAX_BEAM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptk_pkg::emit_req_t                  req,
  input  logic [ptk_pkg::POS_W-1:0]           ranked_pos [MAX_BEAM],
  output logic                                free,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ptk_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);
  import ptk_pkg::*;

  localparam int IW = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;

  logic [POS_W-1:0]  snap_r [MAX_BEAM];
  logic [BEAM_W-1:0] count_r, used_r, rank_r;
  logic              busy_r;
  logic              fire, is_last;
  logic [RANK_POS_W-1:0] rank_pos;

  assign fire    = busy_r && out_tready;
  assign is_last = (rank_r + BEAM_W'(1)) == count_r;
  assign free    = !busy_r || (fire && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rank_r <= '0;
    end else begin
      if (req.load) begin
        busy_r <= 1'b1;
        rank_r <= '0;
      end else if (fire) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end
        rank_r <= rank_r + BEAM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      snap_r  <= ranked_pos;
      count_r <= req.count;
      used_r  <= req.used;
    end
  end

  assign rank_pos   = (rank_r < used_r) ? {1'b0, snap_r[IW'(rank_r)]} : NO_POSITION;
  assign out_tvalid = busy_r;
  assign out_tdata  = {{(OUT_DATA_W - RANK_W - RANK_POS_W){1'b0}}, rank_r[RANK_W-1:0], rank_pos};
  assign out_tlast  = is_last;

  a_rank_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rank_r < count_r && used_r <= count_r))
    else $error("rank counter outside row");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !free) |-> !req.load)
    else $error("new row loaded while previous row pending");

endmodule

FILE: sv/per_sequence_top_k_index_select.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_tvalid / in_tready   | tdata[31:0] score, tlast last_of_sequence
// out     | output    | out_tvalid / out_tready | tdata[16:0] rank_position, [19:17] rank,
//         |           |                         | tlast last_of_row
// cfg     | input     | cfg_valid / cfg_ready   | cfg_data[3:0] beam width
//
// One score beat per cycle; compare-and-insert into the slots completes in the accept cycle.
// The last beat of a sequence copies the ranking into an output row of beam width beats (1 to 8),
// drained one beat a cycle while out_tready is high, from the cycle after that beat.
// Only a last beat stalls, and only while a previous row is still draining.
// rst_n is synchronous: clears slot count, position counter, row state; beam width returns to 1.
// Output stalls hold the current result beat; cfg_ready is always high.
module per_sequence_top_k_index_select #(
  parameter int MAX_BEAM    = 8,
  parameter int MAX_SEQ_LEN = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ptk_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] score
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ptk_pkg::OUT_DATA_W-1:0]     out_tdata,  // [16:0] rank_position, [19:17] rank
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptk_pkg::BEAM_W-1:0]         cfg_data
);
  import ptk_pkg::*;

  logic [BEAM_W-1:0] beam_r;
  logic              beat, free;
  emit_req_t         req;
  logic [POS_W-1:0]  ranked_pos [MAX_BEAM];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_r <= BEAM_W'(1);
    end else if (cfg_valid) begin
      beam_r <= cfg_data;
    end
  end

  assign in_tready = free || !in_tlast;
  assign beat      = in_tvalid && in_tready;

  ptk_slots #(
    .MAX_BEAM    (MAX_BEAM),
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .score      ($signed(in_tdata[SCORE_W-1:0])),
    .last       (in_tlast),
    .beam       (beam_r),
    .req        (req),
    .ranked_pos (ranked_pos)
  );

  ptk_emit #(
    .MAX_BEAM (MAX_BEAM)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .ranked_pos (ranked_pos),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/per_sequence_top_k_index_select_test.sv
`timescale 1ns / 1ps

module per_sequence_top_k_index_select_test;
  import ptk_pkg::*;

  localparam int                BEAM_LIMIT   = 8;
  localparam logic [POS_W-1:0]  POS_SAT      = 16'hFFFF;
  localparam logic [31:0]       SCORE_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]       SCORE_MIN    = 32'h8000_0000;
  localparam logic [31:0]       SIGN_FLIP    = 32'h8000_0000;
  localparam int                DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [RANK_POS_W-1:0] pos;
    logic [RANK_W-1:0]     rank;
    logic                  last;
  } rank_beat_t;

  typedef struct packed {
    logic                  cfg_en;
    logic [BEAM_W-1:0]     cfg_val;
    logic [SCORE_W-1:0]    score;
    logic                  last;
    logic                  known;
    logic [RANK_POS_W-1:0] known_pos;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BEAM_W-1:0]     cfg_data = '0;

  // travel with the score beat; a known row carries its rank-0 position
  logic                  beat_known = 1'b0;
  logic [RANK_POS_W-1:0] beat_known_pos = '0;

  logic [BEAM_W-1:0]     beam_reg = 4'd1;
  logic [SCORE_W-1:0]    kept_key [BEAM_LIMIT];
  logic [POS_W-1:0]      kept_pos [BEAM_LIMIT];
  int                    kept_count = 0;
  logic [POS_W-1:0]      next_pos = '0;
  rank_beat_t            pending_ranks [$];

  int errors = 0;
  int scores_seen = 0;
  int sequences_seen = 0;
  int ranks_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  per_sequence_top_k_index_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int beam_depth(input logic [BEAM_W-1:0] b);
    if (b == 0) return 1;
    if (b > BEAM_LIMIT) return BEAM_LIMIT;
    return int'(b);
  endfunction

  task automatic rank_score(input logic [SCORE_W-1:0] score, input logic last,
                            input logic known, input logic [RANK_POS_W-1:0] known_pos);
    int k;
    int used;
    int at;
    int i;
    logic [SCORE_W-1:0] key;
    rank_beat_t beat;
    k = beam_depth(beam_reg);
    key = score ^ SIGN_FLIP;
    used = (kept_count < k) ? kept_count : k;
    at = 0;
    while (at < used && kept_key[at] >= key) at++;
    if (at < k) begin
      if (used == k) used = k - 1;
      for (i = used; i > at; i--) begin
        kept_key[i] = kept_key[i-1];
        kept_pos[i] = kept_pos[i-1];
      end
      kept_key[at] = key;
      kept_pos[at] = next_pos;
      kept_count = used + 1;
    end
    if (next_pos != POS_SAT) next_pos++;
    if (last) begin
      used = (kept_count < k) ? kept_count : k;
      if (known) begin
        beat.pos = known_pos;
        beat.rank = '0;
        beat.last = 1'b1;
        pending_ranks.push_back(beat);
      end else begin
        for (i = 0; i < k; i++) begin
          beat.pos = (i < used) ? {1'b0, kept_pos[i]} : NO_POSITION;
          beat.rank = RANK_W'(i);
          beat.last = (i == k - 1);
          pending_ranks.push_back(beat);
        end
      end
      kept_count = 0;
      next_pos = '0;
      sequences_seen++;
    end
  endtask

  always @(posedge clk) begin
    rank_beat_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) beam_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        scores_seen++;
        rank_score(in_tdata[SCORE_W-1:0], in_tlast, beat_known, beat_known_pos);
      end
      if (out_tvalid && out_tready) begin
        if (pending_ranks.size() == 0) begin
          $error("unexpected result beat: rank_position %0h", out_tdata[16:0]);
          errors++;
        end else begin
          want = pending_ranks.pop_front();
          ranks_checked++;
          if (out_tdata[16:0] !== want.pos) begin
            $error("rank_position: expected %0h, got %0h", want.pos, out_tdata[16:0]);
            errors++;
          end
          if (out_tdata[19:17] !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, out_tdata[19:17]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_row: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
          if (out_tdata[OUT_DATA_W-1:20] !== '0) begin
            $error("tdata pad: expected 0, got %0h", out_tdata[OUT_DATA_W-1:20]);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_beat(input logic [SCORE_W-1:0] score, input logic last,
                           input logic known, input logic [RANK_POS_W-1:0] known_pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= score;
    in_tlast <= last;
    beat_known <= known;
    beat_known_pos <= known_pos;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_ranks();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_beam(input logic [BEAM_W-1:0] value);
    drain_ranks();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t row(input logic cfg_en, input logic [BEAM_W-1:0] cfg_val,
                                    input logic [SCORE_W-1:0] score, input logic last,
                                    input logic known, input logic [RANK_POS_W-1:0] pos);
    plan_row_t r;
    r.cfg_en = cfg_en;
    r.cfg_val = cfg_val;
    r.score = score;
    r.last = last;
    r.known = known;
    r.known_pos = pos;
    return r;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score(input int mode);
    logic [SCORE_W-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = 32'($urandom_range(8)) - 32'd4;
      2: begin
        case ($urandom_range(3))
          0: v = SCORE_MAX;
          1: v = SCORE_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = 32'($urandom_range(32'h0003_0000)) - 32'h0001_8000;
    endcase
    return v;
  endfunction

  task automatic run_phase(input int send_pct, input int recv_pct, input int item_goal);
    int sent;
    int len;
    int mode;
    int i;
    logic mid_cfg;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < item_goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      mode = $urandom_range(3);
      mid_cfg = (len > 1) && ($urandom_range(7) == 0);
      for (i = 0; i < len; i++) begin
        if (mid_cfg && i == len / 2) write_beam(4'($urandom_range(15)));
        send_beat(pick_score(mode), i == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  initial begin
    plan_row_t plan [$];
    int i;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // beam of one after reset: rank 0 only
    plan.push_back(row(1'b0, 4'd0,  SCORE_MAX,     1'b1, 1'b1, 17'd0));
    plan.push_back(row(1'b0, 4'd0,  SCORE_MIN,     1'b1, 1'b1, 17'd0));
    plan.push_back(row(1'b0, 4'd0,  SCORE_MIN,     1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  SCORE_MAX,     1'b1, 1'b1, 17'd1));
    plan.push_back(row(1'b0, 4'd0,  32'd5,         1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd5,         1'b1, 1'b1, 17'd0));
    // short sequence under a wide beam: padding
    plan.push_back(row(1'b1, 4'd8,  32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd0,         1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd1,         1'b1, 1'b0, '0));
    // zero beam acts as one
    plan.push_back(row(1'b1, 4'd0,  32'd3,         1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd7,         1'b1, 1'b1, 17'd1));
    // beam above the limit acts as the limit
    plan.push_back(row(1'b1, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd1,         1'b1, 1'b0, '0));
    // beam narrowed mid-sequence
    plan.push_back(row(1'b1, 4'd3,  32'd10,        1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd20,        1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd30,        1'b0, 1'b0, '0));
    plan.push_back(row(1'b1, 4'd1,  32'd5,         1'b1, 1'b0, '0));
    // beam widened mid-sequence
    plan.push_back(row(1'b1, 4'd1,  32'd9,         1'b0, 1'b0, '0));
    plan.push_back(row(1'b0, 4'd0,  32'd8,         1'b0, 1'b0, '0));
    plan.push_back(row(1'b1, 4'd4,  32'd7,         1'b1, 1'b0, '0));

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].cfg_en) write_beam(plan[i].cfg_val);
      send_beat(plan[i].score, plan[i].last, plan[i].known, plan[i].known_pos);
    end

    write_beam(4'd8);
    run_phase(0, 0, 90);
    write_beam(4'($urandom_range(7, 2)));
    run_phase(83, 0, 90);
    write_beam(4'd1);
    run_phase(0, 83, 90);
    write_beam(4'd15);
    run_phase(29, 29, 90);

    drain_ranks();
    repeat (8) @(posedge clk);
    $display("covered %0d scores in %0d sequences, %0d result beats checked",
             scores_seen, sequences_seen, ranks_checked);
    $display("beam sizes 0..15, mid-sequence beam changes, ties, padding, stalls on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: per_sequence_top_k_index_select.f
sv/ptk_pkg.sv
sv/ptk_slots.sv
sv/ptk_emit.sv
sv/per_sequence_top_k_index_select.sv
tb/per_sequence_top_k_index_select_test.sv
